>>> rtl/pixel_replicating_upscaler_top_assert.svh
// assertion macros for the pixel upscaler checker
`ifndef PIXEL_REPLICATING_UPSCALER_TOP_ASSERT_SVH
`define PIXEL_REPLICATING_UPSCALER_TOP_ASSERT_SVH

// condition c must hold in the same cycle as a
`define UPSC_ASSERT_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%m: same-cycle check failed");

// condition c must hold in the cycle after a
`define UPSC_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%m: next-cycle check failed");

`endif

>>> rtl/upsc_pkg.sv
// shared types, constants and helpers of the pixel upscaler
`default_nettype none

package upsc_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_SCALE   = 100;
   localparam int PIXEL_W     = 24;
   localparam int SCALE_W     = 7;
   localparam int WIDTH_W     = 12;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int COUNT_W     = $clog2(MAX_WIDTH + 1);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = WIDTH_W;
   // power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_PIXEL  = 2'd0,
      ST_PAD    = 2'd1,
      ST_LOADED = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SCALE        = 1'b0,
      REG_SOURCE_WIDTH = 1'b1
   } csr_reg_type;

   // work item handed from the front to the back
   typedef struct packed {
      logic               mem_wr;
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] pixel;
      status_type         status;
      logic [1:0]         pad;
      logic               row_end;
      logic               group_end;
   } cmd_type;

   // (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4
   function automatic logic [1:0] pad_count(logic [COUNT_W-1:0] w, logic [SCALE_W-1:0] s);
      logic [3:0] prod;
      prod = {2'b00, w[1:0]} * {2'b00, s[1:0]};
      return prod[1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/upsc_req_if.sv
// request channel of the pixel upscaler
`default_nettype none

interface upsc_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [23:0] pixel_in;

   modport source (output valid, output operation, output pixel_in, input ready);
   modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> rtl/upsc_rsp_if.sv
// response channel of the pixel upscaler
`default_nettype none

interface upsc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [23:0] pixel_out;
   logic [1:0]  pad_bytes;
   logic        row_end;
   logic        group_end;

   modport source (output valid, output status, output pixel_out, output pad_bytes,
                   output row_end, output group_end, input ready);
   modport sink (input valid, input status, input pixel_out, input pad_bytes,
                 input row_end, input group_end, output ready);
endinterface

`default_nettype wire

>>> rtl/upsc_queue.sv
// small command queue between the front and the back
`default_nettype none

module upsc_queue import upsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    head_valid
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/upsc_front.sv
// front end: config registers, row counters and classification of each request
`default_nettype none

module upsc_front import upsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   upsc_req_if.sink               req,
   output cmd_type                cmd,
   output logic                   cmd_push,
   input  logic                   queue_full
);

   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [WIDTH_W-1:0] width_ff, width_in;
   logic [COUNT_W-1:0] loaded_count_ff, loaded_count_in;
   logic [COUNT_W-1:0] out_column_ff, out_column_in;
   logic [SCALE_W-1:0] pixel_repeat_ff, pixel_repeat_in;
   logic [SCALE_W-1:0] row_repeat_ff, row_repeat_in;
   logic               padding_due_ff, padding_due_in;

   logic               accept;
   logic [SCALE_W-1:0] eff_scale;
   logic [COUNT_W-1:0] eff_width;
   logic [SCALE_W:0]   scale_wide;
   logic [SCALE_W:0]   pixel_repeat_next;
   logic [SCALE_W:0]   row_repeat_next;
   logic [COUNT_W-1:0] out_column_next;
   logic               row_full;
   logic [1:0]         pad;
   logic               finish;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign cmd_push  = accept;

   always_comb begin
      if (scale_ff == '0) begin
         eff_scale = SCALE_W'(1);
      end else if (scale_ff > SCALE_W'(MAX_SCALE)) begin
         eff_scale = SCALE_W'(MAX_SCALE);
      end else begin
         eff_scale = scale_ff;
      end
      if (width_ff == '0) begin
         eff_width = COUNT_W'(1);
      end else if (COUNT_W'(width_ff) > COUNT_W'(MAX_WIDTH)) begin
         eff_width = COUNT_W'(MAX_WIDTH);
      end else begin
         eff_width = COUNT_W'(width_ff);
      end
   end

   assign scale_wide        = {1'b0, eff_scale};
   assign pixel_repeat_next = {1'b0, pixel_repeat_ff} + (SCALE_W+1)'(1);
   assign row_repeat_next   = {1'b0, row_repeat_ff} + (SCALE_W+1)'(1);
   assign out_column_next   = out_column_ff + COUNT_W'(1);
   assign row_full          = (loaded_count_ff >= eff_width);
   assign pad               = pad_count(eff_width, eff_scale);

   always_comb begin
      scale_in        = scale_ff;
      width_in        = width_ff;
      loaded_count_in = loaded_count_ff;
      out_column_in   = out_column_ff;
      pixel_repeat_in = pixel_repeat_ff;
      row_repeat_in   = row_repeat_ff;
      padding_due_in  = padding_due_ff;
      finish          = 1'b0;
      cmd             = '0;
      cmd.status      = ST_REJECT;

      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_SCALE:        scale_in = csr_wdata[SCALE_W-1:0];
            REG_SOURCE_WIDTH: width_in = csr_wdata[WIDTH_W-1:0];
            default:          ;
         endcase
      end

      if (accept) begin
         if (op_type'(req.operation) == OP_LOAD) begin
            if (!row_full) begin
               cmd.mem_wr      = 1'b1;
               cmd.addr        = loaded_count_ff[ADDR_W-1:0];
               cmd.pixel       = req.pixel_in;
               cmd.status      = ST_LOADED;
               loaded_count_in = loaded_count_ff + COUNT_W'(1);
            end
         end else if (row_full) begin
            if (padding_due_ff) begin
               cmd.status  = ST_PAD;
               cmd.pad     = pad;
               cmd.row_end = 1'b1;
               finish      = 1'b1;
            end else begin
               cmd.status = ST_PIXEL;
               cmd.addr   = out_column_ff[ADDR_W-1:0];
               if (pixel_repeat_next >= scale_wide) begin
                  pixel_repeat_in = '0;
                  out_column_in   = out_column_next;
                  if (out_column_next >= eff_width) begin
                     // without padding the last pixel closes the row itself
                     if (pad == 2'd0) begin
                        cmd.row_end = 1'b1;
                        finish      = 1'b1;
                     end else begin
                        padding_due_in = 1'b1;
                     end
                  end
               end else begin
                  pixel_repeat_in = pixel_repeat_next[SCALE_W-1:0];
               end
            end
         end

         if (finish) begin
            out_column_in   = '0;
            pixel_repeat_in = '0;
            padding_due_in  = 1'b0;
            if (row_repeat_next >= scale_wide) begin
               // last replica frees the line store
               row_repeat_in   = '0;
               loaded_count_in = '0;
               cmd.group_end   = 1'b1;
            end else begin
               row_repeat_in = row_repeat_next[SCALE_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff        <= SCALE_W'(1);
         width_ff        <= WIDTH_W'(1);
         loaded_count_ff <= '0;
         out_column_ff   <= '0;
         pixel_repeat_ff <= '0;
         row_repeat_ff   <= '0;
         padding_due_ff  <= 1'b0;
      end else begin
         scale_ff        <= scale_in;
         width_ff        <= width_in;
         loaded_count_ff <= loaded_count_in;
         out_column_ff   <= out_column_in;
         pixel_repeat_ff <= pixel_repeat_in;
         row_repeat_ff   <= row_repeat_in;
         padding_due_ff  <= padding_due_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/upsc_back.sv
// back end: line store access and registered response stage
`default_nettype none

module upsc_back import upsc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   head,
   input  logic      head_valid,
   output logic      pop,
   upsc_rsp_if.source rsp
);

   logic [PIXEL_W-1:0] line_store [MAX_WIDTH];
   logic [PIXEL_W-1:0] rd_data_ff;
   cmd_type            out_cmd_ff;
   logic               out_valid_ff, out_valid_in;

   // take the next command whenever the output slot is empty or drains now
   assign pop          = head_valid && (!out_valid_ff || rsp.ready);
   assign out_valid_in = pop ? 1'b1 : (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (pop && head.mem_wr) begin
         line_store[head.addr] <= head.pixel;
      end
      if (pop && head.status == ST_PIXEL) begin
         rd_data_ff <= line_store[head.addr];
      end
      if (pop) begin
         out_cmd_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.status    = out_cmd_ff.status;
   assign rsp.pixel_out = (out_cmd_ff.status == ST_PIXEL) ? rd_data_ff : '0;
   assign rsp.pad_bytes = out_cmd_ff.pad;
   assign rsp.row_end   = out_cmd_ff.row_end;
   assign rsp.group_end = out_cmd_ff.group_end;

endmodule

`default_nettype wire

>>> rtl/pixel_replicating_upscaler_top.sv
// an accepted request is written into the command queue and then registered in the response stage
// throughput: one request per cycle while the queue is not full, set by the single line-store port in the back end
// a four-entry command queue lets the request side run on while the response side stalls
// reset clears the row counters, the queue and the response stage; scale and width go to 1
// the line store is not cleared; there is no clearing pass and requests are taken at once
`default_nettype none

module pixel_replicating_upscaler_top import upsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   upsc_req_if.sink               req_if,
   upsc_rsp_if.source             rsp_if
);

   cmd_type front_cmd;
   logic    front_push;
   logic    queue_full;
   cmd_type queue_head;
   logic    queue_head_valid;
   logic    back_pop;

   upsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req        (req_if),
      .cmd        (front_cmd),
      .cmd_push   (front_push),
      .queue_full (queue_full)
   );

   upsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (back_pop),
      .head       (queue_head),
      .head_valid (queue_head_valid)
   );

   upsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (queue_head),
      .head_valid (queue_head_valid),
      .pop        (back_pop),
      .rsp        (rsp_if)
   );

endmodule

`default_nettype wire

>>> rtl/upsc_checker.sv
// port-level checks of the pixel upscaler and their binding to the top level
`default_nettype none
`include "pixel_replicating_upscaler_top_assert.svh"

module upsc_checker import upsc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [23:0] rsp_pixel_out,
   input logic [1:0]  rsp_pad_bytes,
   input logic        rsp_row_end,
   input logic        rsp_group_end
);

   // a stalled response keeps its transaction
   `UPSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_pixel_out) && $stable(rsp_row_end))

   `UPSC_ASSERT_SAME(a_pixel_zero, clock, reset, rsp_valid && rsp_status != ST_PIXEL, rsp_pixel_out == '0)

   `UPSC_ASSERT_SAME(a_pad_zero, clock, reset, rsp_valid && rsp_status != ST_PAD, rsp_pad_bytes == '0)

   // the group closes only together with a row
   `UPSC_ASSERT_SAME(a_group_in_row, clock, reset, rsp_valid && rsp_group_end, rsp_row_end && (rsp_status == ST_PIXEL || rsp_status == ST_PAD))

   `UPSC_ASSERT_SAME(a_load_no_marks, clock, reset, rsp_valid && (rsp_status == ST_LOADED || rsp_status == ST_REJECT), !rsp_row_end && !rsp_group_end)

endmodule

bind pixel_replicating_upscaler_top upsc_checker u_upsc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_status    (rsp_if.status),
   .rsp_pixel_out (rsp_if.pixel_out),
   .rsp_pad_bytes (rsp_if.pad_bytes),
   .rsp_row_end   (rsp_if.row_end),
   .rsp_group_end (rsp_if.group_end)
);

`default_nettype wire

>>> tb/pixel_replicating_upscaler_top_tb.sv
// self-checking testbench for the pixel replicating upscaler with a built-in row predictor
module pixel_replicating_upscaler_top_tb;
   import upsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 4;

   typedef struct packed {
      op_type      op;
      logic [23:0] pixel;
   } upscale_req_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] pixel;
      logic [1:0]  pad;
      logic        row_end;
      logic        group_end;
   } upscale_unit_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   upsc_req_if req_bus ();
   upsc_rsp_if rsp_bus ();

   pixel_replicating_upscaler_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   // predictor copy of the registers and the row state
   logic [6:0]  cfg_scale;
   logic [11:0] cfg_width;
   logic [23:0] row_pixels [MAX_WIDTH];
   int          stored_count;
   int          emit_column;
   int          copy_count;
   int          line_copy;
   bit          pad_pending;

   upscale_req_type  queued_reqs [$];
   upscale_unit_type predicted_units [$];
   upscale_req_type  req_next;
   upscale_unit_type unit_want;

   int gap_pct;
   int stall_pct;
   int hold_requests;
   int holds_taken;
   int hold_left;
   int quiet_cycles;
   int mismatches;

   function automatic int eff_scale();
      if (cfg_scale == 0) return 1;
      if (cfg_scale > MAX_SCALE) return MAX_SCALE;
      return cfg_scale;
   endfunction

   function automatic int eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   // zero bytes that bring a row of w*s 3-byte pixels to a multiple of four
   function automatic logic [1:0] pad_of(int w, int s);
      return 2'((4 - ((w * s * 3) & 3)) & 3);
   endfunction

   function automatic logic close_row(int s);
      logic last;
      last = (line_copy + 1 >= s);
      emit_column = 0;
      copy_count = 0;
      pad_pending = 1'b0;
      if (last) begin
         line_copy = 0;
         stored_count = 0;
      end else begin
         line_copy++;
      end
      return last;
   endfunction

   function automatic upscale_unit_type upscale_step(op_type op, logic [23:0] pix);
      upscale_unit_type u;
      int w;
      int s;
      w = eff_width();
      s = eff_scale();
      u = '{ST_REJECT, 24'd0, 2'd0, 1'b0, 1'b0};
      if (op == OP_LOAD) begin
         if (stored_count < w) begin
            row_pixels[stored_count] = pix;
            stored_count++;
            u.status = ST_LOADED;
         end
      end else if (stored_count >= w) begin
         if (pad_pending) begin
            u.status = ST_PAD;
            u.pad = pad_of(w, s);
            u.row_end = 1'b1;
            u.group_end = close_row(s);
         end else begin
            u.status = ST_PIXEL;
            u.pixel = row_pixels[emit_column % MAX_WIDTH];
            copy_count++;
            if (copy_count >= s) begin
               copy_count = 0;
               emit_column++;
               if (emit_column >= w) begin
                  if (pad_of(w, s) == 0) begin
                     u.row_end = 1'b1;
                     u.group_end = close_row(s);
                  end else begin
                     pad_pending = 1'b1;
                  end
               end
            end
         end
      end
      return u;
   endfunction

   function automatic void queue_req(op_type op, logic [23:0] pix);
      queued_reqs.push_back('{op, pix});
   endfunction

   // whole load/emit groups for the current shape, starting from where the row stands
   function automatic void queue_groups(int n_items);
      int w;
      int s;
      int row_units;
      int loads;
      int emits;
      int added;
      int k;
      w = eff_width();
      s = eff_scale();
      row_units = w * s + ((pad_of(w, s) != 0) ? 1 : 0);
      if (stored_count < w) begin
         loads = w - stored_count;
         emits = s * row_units;
      end else begin
         loads = 0;
         emits = (emit_column < w) ? (w - emit_column) * s - copy_count : 1;
         if (emits < 1) emits = 1;
         if (pad_pending) emits = 1;
         else emits += row_units - w * s;
         emits += ((line_copy + 1 < s) ? s - line_copy - 1 : 0) * row_units;
      end
      added = 0;
      do begin
         for (k = 0; k < loads; k++) begin
            // emit while the row is still incomplete
            if ($urandom_range(49) == 0) begin
               queue_req(OP_EMIT, 24'($urandom()));
               added++;
            end
            queue_req(OP_LOAD, 24'($urandom()));
         end
         for (k = 0; k < emits; k++) begin
            // load while replicas are still pending
            if ($urandom_range(49) == 0) begin
               queue_req(OP_LOAD, 24'($urandom()));
               added++;
            end
            queue_req(OP_EMIT, 24'($urandom()));
         end
         added += loads + emits;
         if ($urandom_range(9) == 0) begin
            for (k = 0; k < 3; k++) queue_req(op_type'($urandom_range(1)), 24'($urandom()));
            added += 3;
         end
         loads = w;
         emits = s * row_units;
      end while (added < n_items);
   endfunction

   function automatic void check_field(string field, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   task automatic write_reg(csr_reg_type idx, logic [11:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_SCALE) cfg_scale = value[6:0];
      else cfg_width = value;
      @(negedge clock);
   endtask

   task automatic set_shape(int s, int w);
      logic [4:0] junk;
      // bits above the scale field are don't-care
      junk = ($urandom_range(3) == 0) ? 5'($urandom()) : 5'd0;
      write_reg(REG_SCALE, {junk, 7'(s)});
      write_reg(REG_SOURCE_WIDTH, 12'(w));
   endtask

   task automatic wait_quiet();
      while (queued_reqs.size() != 0 || req_bus.valid || predicted_units.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // driver: one transaction offered at a time, held until taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predicted_units.push_back(upscale_step(op_type'(req_bus.operation),
                                                   req_bus.pixel_in));
         if (!req_bus.valid || req_bus.ready) begin
            if (queued_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
               req_next = queued_reqs.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.operation <= req_next.op;
               req_bus.pixel_in <= req_next.pixel;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_units.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual status %0d",
                        $time, rsp_bus.status);
               mismatches++;
            end else begin
               unit_want = predicted_units.pop_front();
               check_field("status", unit_want.status, rsp_bus.status);
               check_field("pixel_out", unit_want.pixel, rsp_bus.pixel_out);
               check_field("pad_bytes", unit_want.pad, rsp_bus.pad_bytes);
               check_field("row_end", unit_want.row_end, rsp_bus.row_end);
               check_field("group_end", unit_want.group_end, rsp_bus.group_end);
            end
         end
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pixel_replicating_upscaler_top verification failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int k;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = REG_SCALE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_LOAD;
      req_bus.pixel_in = '0;
      rsp_bus.ready = 1'b0;
      cfg_scale = 7'd1;
      cfg_width = 12'd1;
      stored_count = 0;
      emit_column = 0;
      copy_count = 0;
      line_copy = 0;
      pad_pending = 1'b0;
      gap_pct = 0;
      stall_pct = 0;
      hold_requests = 0;
      holds_taken = 0;
      hold_left = 0;
      quiet_cycles = 0;
      mismatches = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset shape of one pixel, scale one
      queue_req(OP_EMIT, 24'h000000);   // nothing loaded yet
      queue_req(OP_LOAD, 24'hFFFFFF);
      queue_req(OP_LOAD, 24'h123456);   // row already complete
      queue_req(OP_EMIT, 24'hFFFFFF);
      queue_req(OP_EMIT, 24'h000000);   // one pad byte closes the row
      wait_quiet();
      set_shape(2, 3);
      queue_req(OP_LOAD, 24'h000000);
      queue_req(OP_EMIT, 24'hABCDEF);
      queue_req(OP_LOAD, 24'h800001);
      queue_req(OP_LOAD, 24'h7FFFFE);
      for (k = 0; k < 14; k++) begin
         if (k == 5) queue_req(OP_LOAD, 24'h555555);
         queue_req(OP_EMIT, 24'hAAAAAA);
      end
      wait_quiet();

      // out-of-range register values
      set_shape(0, 0);
      queue_groups(12);
      wait_quiet();
      set_shape(127, 1);
      queue_req(OP_LOAD, 24'($urandom()));
      for (k = 0; k < 230; k++) queue_req(OP_EMIT, 24'($urandom()));
      wait_quiet();
      // shape changes in the middle of a group
      set_shape(3, 5);
      queue_groups(1);
      wait_quiet();
      set_shape(2, 5);
      for (k = 0; k < 3; k++) queue_req(OP_LOAD, 24'($urandom()));
      wait_quiet();
      write_reg(REG_SOURCE_WIDTH, 12'd2);
      queue_req(OP_EMIT, 24'($urandom()));
      queue_req(OP_EMIT, 24'($urandom()));
      queue_req(OP_EMIT, 24'($urandom()));
      wait_quiet();
      write_reg(REG_SOURCE_WIDTH, 12'd4);
      queue_groups(10);
      wait_quiet();
      // width register above the maximum, row left partial so the emit is turned away
      set_shape(1, 4095);
      for (k = 0; k < 8; k++) queue_req(OP_LOAD, 24'($urandom()));
      queue_req(OP_EMIT, 24'($urandom()));
      wait_quiet();

      for (phase = 0; phase < 12; phase++) begin
         wait_quiet();
         case (phase % 4)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 45;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 45;
            end
            default: begin
               gap_pct = 30;
               stall_pct = 30;
            end
         endcase
         if ($urandom_range(9) == 0)
            set_shape($urandom_range(1, 6), $urandom_range(1, 12));
         else
            set_shape($urandom_range(1, 4), $urandom_range(1, 6));
         if (phase == 6) begin
            // receiver holds off while the sender keeps going
            gap_pct = 0;
            stall_pct = 0;
            hold_requests++;
         end
         queue_groups(75);
      end

      wait_quiet();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && predicted_units.size() == 0)
         $display("pixel_replicating_upscaler_top verification clean");
      else
         $display("pixel_replicating_upscaler_top verification failed");
      $finish;
   end

endmodule
